// File: src/dva_pkg.sv
package dva_pkg;

  // Wavetable depth default
  localparam int DVA_TABLE_DEPTH = 256;

  // Item kinds
  localparam logic [1:0] FUNC_TICK        = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON     = 2'd1;
  localparam logic [1:0] FUNC_TABLE_WRITE = 2'd2;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ATK_RATE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEC_RATE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUS_LEVEL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUS_TICKS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REL_RATE  = 3'd4;

  // Register reset values
  localparam logic [7:0]  ATK_RATE_RST  = 8'd8;
  localparam logic [7:0]  DEC_RATE_RST  = 8'd50;
  localparam logic [4:0]  SUS_LEVEL_RST = 5'd20;
  localparam logic [15:0] SUS_TICKS_RST = 16'd2000;
  localparam logic [10:0] REL_RATE_RST  = 11'd200;

  localparam logic [4:0] VOL_MAX = 5'd31;

  // Derived stage boundaries for the reset register values
  localparam int ATK_TIME_RST_I  = 8 * 31;
  localparam int DEC_TIME_RST_I  = ATK_TIME_RST_I + (31 - 20) * 50;
  localparam int REL_START_RST_I = DEC_TIME_RST_I + 2000;
  localparam logic [12:0] ATK_TIME_RST  = 13'(ATK_TIME_RST_I);
  localparam logic [13:0] DEC_TIME_RST  = 14'(DEC_TIME_RST_I);
  localparam logic [16:0] REL_START_RST = 17'(REL_START_RST_I);

  // Channel payloads
  typedef struct packed {
    logic [1:0]        func;
    logic [15:0]       tuning_word;
    logic [7:0]        table_index;
    logic signed [7:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_value;
    logic [4:0] volume_level;
    logic       envelope_active;
  } out_item_t;

  // Envelope control and status
  typedef struct packed {
    logic tick;
    logic note_on;
  } env_ctrl_t;

  typedef struct packed {
    logic [4:0] volume;
    logic       active;
  } env_status_t;

endpackage

// File: src/dva_stream_if.sv
interface dva_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/dva_envelope.sv
module dva_envelope import dva_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  env_ctrl_t              ctrl,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output env_status_t            status,
  output env_status_t            status_next
);

  logic [7:0]  atk_rate, atk_rate_next;
  logic [7:0]  dec_rate, dec_rate_next;
  logic [4:0]  sus_level, sus_level_next;
  logic [15:0] sus_ticks, sus_ticks_next;
  logic [10:0] rel_rate, rel_rate_next;

  logic [12:0] atk_time, atk_time_next;
  logic [13:0] dec_time, dec_time_next;
  logic [16:0] rel_start, rel_start_next;
  logic [4:0]  sl_gap;
  logic [12:0] decay_span;

  logic [4:0]  volume;
  logic [15:0] clock;

  logic [15:0]        clock_inc;
  logic [12:0]        attack_lim;
  logic [4:0]         vol_gap;
  logic [12:0]        decay_lim;
  logic signed [5:0]  rel_gap;
  logic signed [17:0] release_lim;
  logic [15:0]        decay_age;
  logic [16:0]        release_age;
  logic               release_due;
  logic [4:0]         vol_step;
  logic [15:0]        clock_step;

  // Register write decode
  always_comb begin
    atk_rate_next  = atk_rate;
    dec_rate_next  = dec_rate;
    sus_level_next = sus_level;
    sus_ticks_next = sus_ticks;
    rel_rate_next  = rel_rate;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ATK_RATE:  atk_rate_next  = cfg_wdata[7:0];
        REG_DEC_RATE:  dec_rate_next  = cfg_wdata[7:0];
        REG_SUS_LEVEL: sus_level_next = cfg_wdata[4:0];
        REG_SUS_TICKS: sus_ticks_next = cfg_wdata[15:0];
        REG_REL_RATE:  rel_rate_next  = cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Stage boundaries follow the registers, so they are ready at the next edge
  assign sl_gap         = VOL_MAX - sus_level_next;
  assign decay_span     = sl_gap * dec_rate_next;
  assign atk_time_next  = {atk_rate_next, 5'b0} - {5'b0, atk_rate_next};
  assign dec_time_next  = {1'b0, atk_time_next} + {1'b0, decay_span};
  assign rel_start_next = {3'b0, dec_time_next} + {1'b0, sus_ticks_next};

  // Per-tick step terms
  assign clock_inc   = clock + 16'd1;
  assign attack_lim  = atk_rate * volume;
  assign vol_gap     = VOL_MAX - volume;
  assign decay_lim   = vol_gap * dec_rate;
  assign rel_gap     = $signed({1'b0, sus_level}) - $signed({1'b0, volume});
  assign release_lim = rel_gap * $signed({1'b0, rel_rate});
  assign decay_age   = clock_inc - {3'b0, atk_time};
  assign release_age = {1'b0, clock_inc} - rel_start;
  assign release_due = $signed({2'b0, release_age}) > release_lim;

  // Attack, decay, sustain and release rules
  always_comb begin
    vol_step   = volume;
    clock_step = clock;
    if (clock != 16'd0) begin
      clock_step = clock_inc;
      if (clock_inc < {3'b0, atk_time}) begin
        if (clock_inc > {3'b0, attack_lim} && volume != VOL_MAX) begin
          vol_step = volume + 5'd1;
        end
      end else if (clock_inc < {2'b0, dec_time}) begin
        if (decay_age > {3'b0, decay_lim} && volume > sus_level) begin
          vol_step = volume - 5'd1;
        end
      end else if ({1'b0, clock_inc} > rel_start) begin
        if (release_due) begin
          if (volume != 5'd0) begin
            vol_step = volume - 5'd1;
          end else begin
            clock_step = 16'd0;
          end
        end
      end
    end
  end

  assign status      = '{volume: volume, active: (clock != 16'd0)};
  assign status_next = '{volume: vol_step, active: (clock_step != 16'd0)};

  // Registers and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      atk_rate  <= ATK_RATE_RST;
      dec_rate  <= DEC_RATE_RST;
      sus_level <= SUS_LEVEL_RST;
      sus_ticks <= SUS_TICKS_RST;
      rel_rate  <= REL_RATE_RST;
      atk_time  <= ATK_TIME_RST;
      dec_time  <= DEC_TIME_RST;
      rel_start <= REL_START_RST;
      volume    <= 5'd0;
      clock     <= 16'd0;
    end else begin
      atk_rate  <= atk_rate_next;
      dec_rate  <= dec_rate_next;
      sus_level <= sus_level_next;
      sus_ticks <= sus_ticks_next;
      rel_rate  <= rel_rate_next;
      atk_time  <= atk_time_next;
      dec_time  <= dec_time_next;
      rel_start <= rel_start_next;
      if (ctrl.tick) begin
        volume <= vol_step;
        clock  <= clock_step;
      end else if (ctrl.note_on && clock == 16'd0) begin
        clock <= 16'd1;
      end
    end
  end

endmodule

// File: src/dds_voice_with_adsr_envelope.sv
// Channel | Role           | Payload
// --------+----------------+-------------------------------------------------
// cmd     | sink           | func, tuning_word, table_index, table_value
// smp     | source         | pwm_value, volume_level, envelope_active
// cfg_*   | write port     | cfg_we, cfg_index, cfg_wdata (no read-back)
//
// One item per clock while cmd.ready is high. A tick's result appears in the output
// register in the cycle after acceptance; the wavetable read is registered and its mix is
// folded into the following tick's pwm_value.
// Reset is synchronous; the wavetable is not cleared and must be written first.
// cmd.ready drops only while a result is held and smp.ready is low.
module dds_voice_with_adsr_envelope import dva_pkg::*; #(
  parameter int TABLE_DEPTH = DVA_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  dva_stream_if.sink             cmd,
  dva_stream_if.source           smp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic        accept, is_tick, is_note, is_write;
  logic [15:0] phase, phase_step, phase_next;
  logic [7:0]  last_mix, last_mix_eff, mix_comb;
  logic        mix_pending;
  logic [7:0]  rd_data;
  logic [4:0]  vol_used;
  logic signed [13:0] prod;

  logic [AW-1:0] mod_lut [256];
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wave_mem [TABLE_DEPTH];

  env_ctrl_t   env_ctrl;
  env_status_t env_status, env_status_next;

  // Handshake and item decode
  assign cmd.ready = !smp.valid || smp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_tick   = accept && cmd.data.func == FUNC_TICK;
  assign is_note   = accept && cmd.data.func == FUNC_NOTE_ON;
  assign is_write  = accept && cmd.data.func == FUNC_TABLE_WRITE;

  // Byte index folded onto the table depth
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_lut[g] = AW'(g % TABLE_DEPTH);
  end

  assign phase_next = phase + phase_step;
  assign rd_addr    = mod_lut[phase_next[15:8]];
  assign wr_addr    = mod_lut[cmd.data.table_index];

  // Wavetable
  always_ff @(posedge clk) begin
    if (is_write) begin
      wave_mem[wr_addr] <= cmd.data.table_value;
    end
    if (is_tick) begin
      rd_data <= wave_mem[rd_addr];
    end
  end

  // Scaled sample, floor division by 32
  assign prod         = $signed(rd_data) * $signed({1'b0, vol_used});
  assign mix_comb     = prod[12:5];
  assign last_mix_eff = mix_pending ? mix_comb : last_mix;

  // Envelope
  assign env_ctrl = '{tick: is_tick, note_on: is_note};

  dva_envelope u_env (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (env_ctrl),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .status     (env_status),
    .status_next(env_status_next)
  );

  // Oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 16'd0;
      phase_step  <= 16'd0;
      last_mix    <= 8'd0;
      mix_pending <= 1'b0;
    end else begin
      if (is_tick) begin
        phase <= phase_next;
      end
      if (is_note && !env_status.active) begin
        phase_step <= cmd.data.tuning_word;
      end
      if (mix_pending) begin
        last_mix <= mix_comb;
      end
      mix_pending <= is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      vol_used <= env_status.volume;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
    end else if (is_tick) begin
      smp.valid <= 1'b1;
    end else if (smp.ready) begin
      smp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      smp.data.pwm_value       <= last_mix_eff ^ 8'h80;
      smp.data.volume_level    <= env_status_next.volume;
      smp.data.envelope_active <= env_status_next.active;
    end
  end

endmodule

// File: src/dva_checker.sv
module dva_checker import dva_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [1:0] cmd_func,
  input logic       smp_valid,
  input logic       smp_ready,
  input out_item_t  smp_data
);

  // Nothing is offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !smp_valid)
    else $error("result offered after reset");

  // A held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    smp_valid && !smp_ready |=> smp_valid && $stable(smp_data))
    else $error("stalled result changed");

  // Every accepted tick leaves a result
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_func == FUNC_TICK |=> smp_valid)
    else $error("tick gave no result");

  // A result appears only after a tick
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(smp_valid) |-> $past(cmd_valid && cmd_ready && cmd_func == FUNC_TICK))
    else $error("result without a tick");

  // The block never stalls while its result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !smp_valid |-> cmd_ready)
    else $error("input stalled with empty output");

endmodule

bind dds_voice_with_adsr_envelope dva_checker u_dva_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .cmd_func (cmd.data.func),
  .smp_valid(smp.valid),
  .smp_ready(smp.ready),
  .smp_data (smp.data)
);
